>>> src/vcf_pkg.sv
// Shared types, codes and helper functions for the vertex component converter.
`default_nettype none
package vcf_pkg;

  localparam int unsigned CfgWidthW = 3;
  localparam int unsigned CfgTypeW  = 4;
  localparam int unsigned CfgDataW  = 4;

  localparam logic [CfgWidthW-1:0] CompWidthReset = 3'd4;
  localparam logic [CfgTypeW-1:0]  CompTypeReset  = 4'd0;

  // register indexes
  localparam logic CfgIdxWidth = 1'b0;
  localparam logic CfgIdxType  = 1'b1;

  // component widths
  localparam logic [CfgWidthW-1:0] Width1 = 3'd1;
  localparam logic [CfgWidthW-1:0] Width2 = 3'd2;
  localparam logic [CfgWidthW-1:0] Width4 = 3'd4;

  // component types
  localparam logic [CfgTypeW-1:0] TypeFloat   = 4'd0;
  localparam logic [CfgTypeW-1:0] TypeUnorm   = 4'd1;
  localparam logic [CfgTypeW-1:0] TypeUnormS  = 4'd2;
  localparam logic [CfgTypeW-1:0] TypeSnorm   = 4'd3;
  localparam logic [CfgTypeW-1:0] TypeUint    = 4'd4;
  localparam logic [CfgTypeW-1:0] TypeUscaled = 4'd5;
  localparam logic [CfgTypeW-1:0] TypeSint    = 4'd6;
  localparam logic [CfgTypeW-1:0] TypeSscaled = 4'd7;

  localparam logic [31:0] FloatPosInf = 32'h7F80_0000;
  localparam logic [31:0] FloatQnan   = 32'h7FC0_0000;

  // divisor 2^n - 1 of a normalized integer code
  typedef enum logic [1:0] {
    DIV_7  = 2'd0,
    DIV_8  = 2'd1,
    DIV_15 = 2'd2,
    DIV_16 = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } int_req_t;

  typedef struct packed {
    logic        neg;
    div_sel_t    sel;
    logic [15:0] mag;
  } ratio_req_t;

  // half precision to single, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [3:0]  sh;
    logic [10:0] nf;
    logic [31:0] res;
    sgn = {h[15], 31'd0};
    ex  = h[14:10];
    fr  = h[9:0];
    sh  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) sh = 4'(10 - i);
    end
    nf = {1'b0, fr} << sh;
    if (ex == 5'h1f) begin
      res = sgn | ((fr != 10'd0) ? FloatQnan : FloatPosInf);
    end else if (ex == 5'd0) begin
      if (fr == 10'd0) res = sgn;
      else res = sgn | {1'b0, 8'(8'd113 - {4'd0, sh}), nf[9:0], 13'd0};
    end else begin
      res = sgn | {1'b0, 8'({3'd0, ex} + 8'd112), fr, 13'd0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> src/vcf_int2f.sv
// Integer magnitude with sign to single precision, round to nearest even.
`default_nettype none
module vcf_int2f (
  input  wire vcf_pkg::int_req_t req,
  output logic [31:0]            float_bits
);

  logic [4:0]  lz;
  logic [31:0] norm;
  logic [24:0] mant;
  logic        rnd;
  logic [7:0]  expo;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (req.mag[i]) lz = 5'(31 - i);
    end
    norm = req.mag << lz;
    rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = 8'(8'd158 - {3'd0, lz});
    if (mant[24]) expo = 8'(expo + 8'd1);
    if (req.mag == 32'd0) float_bits = 32'd0;
    else float_bits = {req.neg, expo, (mant[24] ? 23'd0 : mant[22:0])};
  end

endmodule
`default_nettype wire

>>> src/vcf_ratio2f.sv
// Code divided by 2^n - 1 to single precision: the quotient's binary
// expansion is the n-bit code repeated, and it never terminates.
`default_nettype none
module vcf_ratio2f (
  input  wire vcf_pkg::ratio_req_t req,
  output logic [31:0]              float_bits
);

  logic [63:0] x7, x8, x15, x16, x, xs;
  logic [4:0]  lz16, lz;
  logic [24:0] mant;
  logic [7:0]  expo;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      x7[63-i]  = req.mag[6 - (i % 7)];
      x8[63-i]  = req.mag[7 - (i % 8)];
      x15[63-i] = req.mag[14 - (i % 15)];
      x16[63-i] = req.mag[15 - (i % 16)];
    end
    lz16 = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (req.mag[i]) lz16 = 5'(15 - i);
    end
    case (req.sel)
      vcf_pkg::DIV_7:  begin x = x7;  lz = 5'(lz16 - 5'd9); end
      vcf_pkg::DIV_8:  begin x = x8;  lz = 5'(lz16 - 5'd8); end
      vcf_pkg::DIV_15: begin x = x15; lz = 5'(lz16 - 5'd1); end
      default:         begin x = x16; lz = lz16;            end
    endcase
    xs = x << lz[3:0];
    // tail is always nonzero, so round on the round bit alone
    mant = {1'b0, xs[63:40]} + {24'd0, xs[39]};
    expo = 8'(8'd126 - {3'd0, lz});
    if (mant[24]) expo = 8'(expo + 8'd1);
    if (req.mag == 16'd0) float_bits = 32'd0;
    else float_bits = {req.neg, expo, (mant[24] ? 23'd0 : mant[22:0])};
  end

endmodule
`default_nettype wire

>>> src/vertex_component_to_float.sv
// Top level of the vertex component to single-precision converter.
// Usage:
//   Input channel in_valid/in_ready carries in_raw_bits, one component
//   packed little-endian (low byte or low halfword for narrow widths).
//   Output channel out_valid/out_ready carries out_float_bits.
//   cfg_we/cfg_index/cfg_wdata write comp_width (index 0) and comp_type
//   (index 1); write them only while no request is in flight.
// Timing:
//   A request sits in an input register, converts in one combinational
//   pass and lands in the result register, which drives out_valid. One
//   request per cycle is sustained while out_ready stays high.
// Reset:
//   rst_n low empties both stages and loads comp_width=4, comp_type=0.
// Stall:
//   With out_ready low the result holds; the input stage still takes one
//   more request if it is empty, then in_ready drops until the result is taken.
`default_nettype none
module vertex_component_to_float (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [31:0] in_raw_bits,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [31:0] out_float_bits,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [vcf_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [vcf_pkg::CfgWidthW-1:0] width_r;
  logic [vcf_pkg::CfgTypeW-1:0]  type_r;
  logic        s1_valid_r, s2_valid_r;
  logic [31:0] raw_r, res_r, res_nxt;
  logic        s2_free;

  vcf_pkg::int_req_t   int_req;
  vcf_pkg::ratio_req_t ratio_req;
  logic [31:0] int_f, ratio_f;
  logic [15:0] h;
  logic [7:0]  b;

  assign s2_free  = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_free;
  assign out_valid = s2_valid_r;
  assign out_float_bits = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= vcf_pkg::CompWidthReset;
      type_r     <= vcf_pkg::CompTypeReset;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vcf_pkg::CfgIdxWidth) width_r <= cfg_wdata[2:0];
        else type_r <= cfg_wdata[3:0];
      end
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_free) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) raw_r <= in_raw_bits;
    if (s2_free && s1_valid_r) res_r <= res_nxt;
  end

  assign h = raw_r[15:0];
  assign b = raw_r[7:0];

  always_comb begin
    int_req   = '{neg: 1'b0, mag: raw_r};
    ratio_req = '{neg: 1'b0, sel: vcf_pkg::DIV_16, mag: h};
    if (width_r == vcf_pkg::Width4) begin
      int_req.neg = raw_r[31] && (type_r == vcf_pkg::TypeSint ||
                                  type_r == vcf_pkg::TypeSscaled);
      int_req.mag = int_req.neg ? 32'(-raw_r) : raw_r;
    end else begin
      int_req.neg = h[15] && (type_r == vcf_pkg::TypeSint ||
                              type_r == vcf_pkg::TypeSscaled);
      int_req.mag = {16'd0, (int_req.neg ? 16'(-h) : h)};
    end
    if (width_r == vcf_pkg::Width1) begin
      if (type_r == vcf_pkg::TypeSnorm) begin
        ratio_req.sel = vcf_pkg::DIV_7;
        ratio_req.neg = b[7];
        ratio_req.mag = {8'd0, (b == 8'h80) ? 8'd127 : (b[7] ? 8'(-b) : b)};
      end else begin
        ratio_req.sel = vcf_pkg::DIV_8;
        ratio_req.mag = {8'd0, b};
      end
    end else if (type_r == vcf_pkg::TypeSnorm) begin
      ratio_req.sel = vcf_pkg::DIV_15;
      ratio_req.neg = h[15];
      ratio_req.mag = (h == 16'h8000) ? 16'd32767 : (h[15] ? 16'(-h) : h);
    end
  end

  vcf_int2f u_int2f (
    .req        (int_req),
    .float_bits (int_f)
  );

  vcf_ratio2f u_ratio2f (
    .req        (ratio_req),
    .float_bits (ratio_f)
  );

  always_comb begin
    res_nxt = 32'd0;
    case (width_r)
      vcf_pkg::Width4: begin
        if (type_r inside {vcf_pkg::TypeUint, vcf_pkg::TypeUscaled,
                           vcf_pkg::TypeSint, vcf_pkg::TypeSscaled}) begin
          res_nxt = int_f;
        end else begin
          res_nxt = raw_r;
        end
      end
      vcf_pkg::Width2: begin
        case (type_r)
          vcf_pkg::TypeFloat:   res_nxt = vcf_pkg::half_to_single(h);
          vcf_pkg::TypeUnorm,
          vcf_pkg::TypeUnormS,
          vcf_pkg::TypeSnorm:   res_nxt = ratio_f;
          vcf_pkg::TypeUint,
          vcf_pkg::TypeUscaled,
          vcf_pkg::TypeSint,
          vcf_pkg::TypeSscaled: res_nxt = int_f;
          default:              res_nxt = 32'd0;
        endcase
      end
      vcf_pkg::Width1: begin
        if (type_r inside {vcf_pkg::TypeUnorm, vcf_pkg::TypeUnormS,
                           vcf_pkg::TypeSnorm}) begin
          res_nxt = ratio_f;
        end
      end
      default: res_nxt = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/vcf_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module vcf_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_float_bits
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_float_bits))
    else $error("result changed while stalled");

endmodule

bind vertex_component_to_float vcf_checker u_vcf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_float_bits (out_float_bits)
);
`default_nettype wire
